// ===== design/cov_pkg.sv =====
// Shared definitions for the cursor overlay block: item action codes,
// configuration register indexes and fixed field widths.
// No dependencies; used by cursor_overlay and cov_checker.
`default_nettype none

package cov_pkg;

    // Width of the action selector and its codes.
    localparam int ACTION_W = 3;
    localparam logic [ACTION_W-1:0] ACT_LOAD_PIXEL = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_MASK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_MOVE       = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_HIDE       = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SHOW       = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_PIXEL      = 3'd5;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_X         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_Y         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_VALID  = 3'd6;

    // Fixed register and field widths.
    localparam int HOT_W   = 6;
    localparam int CSIZE_W = 7;
    localparam int HIDE_W  = 8;
    localparam int MASK_W  = 8;

    // Screen size after reset.
    localparam int SCREEN_W_RESET = 1024;
    localparam int SCREEN_H_RESET = 768;

    // Output sideband bit positions.
    localparam int OUT_USER_W   = 3;
    localparam int OU_HIT_BIT   = 0;
    localparam int OU_AREA_BIT  = 1;
    localparam int OU_SHOWN_BIT = 2;

endpackage

`default_nettype wire

// ===== design/cursor_overlay.sv =====
// Cursor overlay top level: cursor image and mask stores, position and
// hide state, and a two-stage compositing pipeline. Depends on cov_pkg.
`default_nettype none

// Usage
// Requests enter on the slave stream (i_s_*) and each gives exactly one
// result on the master stream (o_m_*). A request loads a cursor pixel or a
// mask byte, moves the cursor, hides or shows it, composites one screen
// pixel, or tests a rectangle against the cursor rectangle.
// Registers are written through the cfg channel, which is always ready;
// write them only while no request is in flight.
// From acceptance, the first stage reads the image and mask stores into
// registers, and the second stage selects the composited pixel into the
// output register.
// Throughput is one request per cycle while the receiver takes results,
// set by the single read port of each store, which serves one pixel lookup per cycle.
// Position, hide count and store writes take effect at the accepting edge,
// so the next request already sees them.
// A synchronous active-low reset restores the register defaults and
// empties the pipeline; store contents are not cleared and read as
// unknown until loaded.
// When the receiver stalls, the output register holds its result and the
// first stage can still take one more request before o_s_tready falls.
module cursor_overlay #(
    parameter int MAX_CURSOR_W = 64,
    parameter int MAX_CURSOR_H = 64,
    parameter int PIXEL_BITS   = 32,
    parameter int COORD_BITS   = 12
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    // Request stream.
    input  wire  i_s_tvalid,
    output logic o_s_tready,
    // tdata from bit 0: coord_x, coord_y, area_width, area_height,
    // pixel_value, mask_byte, zero padding.
    input  wire  [((4*COORD_BITS+2+PIXEL_BITS+cov_pkg::MASK_W+7)/8)*8-1:0] i_s_tdata,
    // tuser from bit 0: action (3 bits), kind_area.
    input  wire  [cov_pkg::ACTION_W:0] i_s_tuser,
    // Result stream.
    output logic o_m_tvalid,
    input  wire  i_m_tready,
    // tdata from bit 0: out_pixel, zero padding.
    output logic [((PIXEL_BITS+7)/8)*8-1:0] o_m_tdata,
    // tuser from bit 0: cursor_hit, in_area, cursor_shown.
    output logic [cov_pkg::OUT_USER_W-1:0] o_m_tuser,
    // Configuration write channel.
    input  wire  i_cfg_valid,
    output logic o_cfg_ready,
    input  wire  [cov_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [COORD_BITS:0] i_cfg_data
);

    localparam int C      = COORD_BITS;
    localparam int OUT_W  = ((PIXEL_BITS + 7) / 8) * 8;
    // Field offsets within the request tdata.
    localparam int OFS_CY = C;
    localparam int OFS_AW = 2 * C;
    localparam int OFS_AH = 3 * C + 1;
    localparam int OFS_PV = 4 * C + 2;
    localparam int OFS_MB = 4 * C + 2 + PIXEL_BITS;
    // Store geometry.
    localparam int XB     = $clog2(MAX_CURSOR_W);
    localparam int YB     = $clog2(MAX_CURSOR_H);
    localparam int DEPTH  = MAX_CURSOR_W * MAX_CURSOR_H;
    localparam int AW     = $clog2(DEPTH);
    localparam int NMW    = (MAX_CURSOR_W + 7) / 8;
    localparam int MWB    = (NMW > 1) ? $clog2(NMW) : 1;
    localparam int MDEPTH = MAX_CURSOR_H * NMW;
    localparam int MAW    = $clog2(MDEPTH);
    // Signed width for position arithmetic.
    localparam int SW     = C + 3;

    // Unpacked request fields.
    logic [cov_pkg::ACTION_W-1:0] w_action;
    logic                         w_kind_area;
    logic [C-1:0]                 w_cx;
    logic [C-1:0]                 w_cy;
    logic [C:0]                   w_aw;
    logic [C:0]                   w_ah;
    logic [PIXEL_BITS-1:0]        w_pv;
    logic [cov_pkg::MASK_W-1:0]   w_mb;

    // Configuration registers.
    logic [cov_pkg::HOT_W-1:0]   r_hot_x;
    logic [cov_pkg::HOT_W-1:0]   r_hot_y;
    logic [cov_pkg::CSIZE_W-1:0] r_cursor_w;
    logic [cov_pkg::CSIZE_W-1:0] r_cursor_h;
    logic [C:0]                  r_screen_w;
    logic [C:0]                  r_screen_h;
    logic                        r_cursor_valid;

    // Cursor state.
    logic [cov_pkg::HIDE_W-1:0] r_hide;
    logic [cov_pkg::HIDE_W-1:0] n_hide;
    logic [C-1:0]               r_pos_x;
    logic [C-1:0]               r_pos_y;

    // Stores.
    logic [PIXEL_BITS-1:0]      r_img [DEPTH];
    logic [cov_pkg::MASK_W-1:0] r_mask [MDEPTH];

    // Pipeline control.
    logic w_adv_out;
    logic w_adv_s1;
    logic w_acc;

    // Geometry.
    logic [cov_pkg::CSIZE_W-1:0] w_eff_w;
    logic [cov_pkg::CSIZE_W-1:0] w_eff_h;
    logic signed [SW-1:0] w_ox, w_oy, w_x, w_y, w_w, w_h, w_dx, w_dy, w_awx, w_ahx;
    logic                 w_shown_now;
    logic                 w_cand;
    logic                 w_area;
    logic                 w_is_pixel;
    logic                 w_ld_pix;
    logic                 w_ld_mask;
    logic [XB-1:0]        w_dx_l;
    logic [YB-1:0]        w_dy_l;
    logic [AW-1:0]        w_img_raddr;
    logic [AW-1:0]        w_img_waddr;
    logic [MAW-1:0]       w_mask_raddr;
    logic [MAW-1:0]       w_mask_waddr;
    logic [cov_pkg::MASK_W-1:0] w_mask_be;

    // First stage registers.
    logic                       r_s1_valid;
    logic [PIXEL_BITS-1:0]      r_s1_pix;
    logic                       r_s1_cand;
    logic                       r_s1_area;
    logic                       r_s1_shown;
    logic [2:0]                 r_s1_bit;
    logic [PIXEL_BITS-1:0]      r_img_q;
    logic [cov_pkg::MASK_W-1:0] r_mask_q;

    // Output registers.
    logic                  r_out_valid;
    logic [PIXEL_BITS-1:0] r_out_pixel;
    logic                  r_out_hit;
    logic                  r_out_area;
    logic                  r_out_shown;
    logic                  w_hit;

    // Field unpacking.
    assign w_action    = i_s_tuser[cov_pkg::ACTION_W-1:0];
    assign w_kind_area = i_s_tuser[cov_pkg::ACTION_W];
    assign w_cx        = i_s_tdata[C-1:0];
    assign w_cy        = i_s_tdata[OFS_CY +: C];
    assign w_aw        = i_s_tdata[OFS_AW +: C+1];
    assign w_ah        = i_s_tdata[OFS_AH +: C+1];
    assign w_pv        = i_s_tdata[OFS_PV +: PIXEL_BITS];
    assign w_mb        = i_s_tdata[OFS_MB +: cov_pkg::MASK_W];

    // Each stage advances when it is empty or its contents move on.
    assign w_adv_out   = !r_out_valid || i_m_tready;
    assign w_adv_s1    = !r_s1_valid || w_adv_out;
    assign o_s_tready  = w_adv_s1;
    assign w_acc       = i_s_tvalid && w_adv_s1;
    assign o_cfg_ready = 1'b1;

    // Cursor rectangle and the request's place relative to it.
    always_comb begin
        w_eff_w = (int'(r_cursor_w) > MAX_CURSOR_W) ?
                  cov_pkg::CSIZE_W'(MAX_CURSOR_W) : r_cursor_w;
        w_eff_h = (int'(r_cursor_h) > MAX_CURSOR_H) ?
                  cov_pkg::CSIZE_W'(MAX_CURSOR_H) : r_cursor_h;
        w_ox    = SW'(r_pos_x) - SW'(r_hot_x);
        w_oy    = SW'(r_pos_y) - SW'(r_hot_y);
        w_x     = SW'(w_cx);
        w_y     = SW'(w_cy);
        w_w     = SW'(w_eff_w);
        w_h     = SW'(w_eff_h);
        w_dx    = w_x - w_ox;
        w_dy    = w_y - w_oy;
        w_awx   = w_x + SW'(w_aw);
        w_ahx   = w_y + SW'(w_ah);
        w_dx_l  = w_dx[XB-1:0];
        w_dy_l  = w_dy[YB-1:0];
    end

    // Request decoding and the overlay and overlap tests.
    always_comb begin
        w_shown_now = r_cursor_valid && (r_hide == '0);
        w_is_pixel  = (w_action == cov_pkg::ACT_PIXEL) && !w_kind_area;
        w_cand      = w_is_pixel && w_shown_now &&
                      ({1'b0, w_cx} < r_screen_w) && ({1'b0, w_cy} < r_screen_h) &&
                      (w_dx >= 0) && (w_dx < w_w) && (w_dy >= 0) && (w_dy < w_h);
        w_area      = (w_action == cov_pkg::ACT_PIXEL) && w_kind_area &&
                      r_cursor_valid &&
                      (w_x < w_ox + w_w) && (w_y < w_oy + w_h) &&
                      (w_awx >= w_ox) && (w_ahx >= w_oy);
        w_ld_pix    = (w_action == cov_pkg::ACT_LOAD_PIXEL) &&
                      (int'(w_cx) < MAX_CURSOR_W) && (int'(w_cy) < MAX_CURSOR_H);
        w_ld_mask   = (w_action == cov_pkg::ACT_LOAD_MASK) &&
                      (int'(w_cy) < MAX_CURSOR_H) && (int'(w_cx) < NMW);
    end

    // Store addresses; a mask word holds eight columns, leftmost in bit 7.
    always_comb begin
        w_img_raddr  = AW'(w_dy_l) * AW'(MAX_CURSOR_W) + AW'(w_dx_l);
        w_img_waddr  = AW'(w_cy[YB-1:0]) * AW'(MAX_CURSOR_W) + AW'(w_cx[XB-1:0]);
        w_mask_raddr = MAW'(w_dy_l) * MAW'(NMW) + MAW'(w_dx_l >> 3);
        w_mask_waddr = MAW'(w_cy[YB-1:0]) * MAW'(NMW) + MAW'(w_cx[MWB-1:0]);
        for (int i = 0; i < cov_pkg::MASK_W; i++) begin
            w_mask_be[cov_pkg::MASK_W-1-i] =
                (int'(w_cx[MWB-1:0]) * 8 + i) < int'(w_eff_w);
        end
    end

    // Hide counter next value: saturating nesting count, cleared by a
    // write of the cursor valid register.
    always_comb begin
        n_hide = r_hide;
        if (i_cfg_valid && i_cfg_index == cov_pkg::CFG_CURSOR_VALID) begin
            n_hide = '0;
        end else if (w_acc && r_cursor_valid) begin
            if (w_action == cov_pkg::ACT_HIDE && r_hide != '1) begin
                n_hide = r_hide + 1'b1;
            end else if (w_action == cov_pkg::ACT_SHOW && r_hide != '0) begin
                n_hide = r_hide - 1'b1;
            end
        end
    end

    // Configuration registers and cursor state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hot_x        <= '0;
            r_hot_y        <= '0;
            r_cursor_w     <= '0;
            r_cursor_h     <= '0;
            r_screen_w     <= (C+1)'(cov_pkg::SCREEN_W_RESET);
            r_screen_h     <= (C+1)'(cov_pkg::SCREEN_H_RESET);
            r_cursor_valid <= 1'b0;
            r_hide         <= '0;
            r_pos_x        <= '0;
            r_pos_y        <= '0;
        end else begin
            r_hide <= n_hide;
            if (w_acc && w_action == cov_pkg::ACT_MOVE) begin
                r_pos_x <= w_cx;
                r_pos_y <= w_cy;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    cov_pkg::CFG_HOT_X:         r_hot_x    <= i_cfg_data[cov_pkg::HOT_W-1:0];
                    cov_pkg::CFG_HOT_Y:         r_hot_y    <= i_cfg_data[cov_pkg::HOT_W-1:0];
                    cov_pkg::CFG_CURSOR_WIDTH:  r_cursor_w <= i_cfg_data[cov_pkg::CSIZE_W-1:0];
                    cov_pkg::CFG_CURSOR_HEIGHT: r_cursor_h <= i_cfg_data[cov_pkg::CSIZE_W-1:0];
                    cov_pkg::CFG_SCREEN_WIDTH:  r_screen_w <= i_cfg_data;
                    cov_pkg::CFG_SCREEN_HEIGHT: r_screen_h <= i_cfg_data;
                    cov_pkg::CFG_CURSOR_VALID:  r_cursor_valid <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Image and mask stores: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_acc && w_ld_pix) begin
            r_img[w_img_waddr] <= w_pv;
        end
        for (int b = 0; b < cov_pkg::MASK_W; b++) begin
            if (w_acc && w_ld_mask && w_mask_be[b]) begin
                r_mask[w_mask_waddr][b] <= w_mb[b];
            end
        end
        if (w_adv_s1) begin
            r_img_q  <= r_img[w_img_raddr];
            r_mask_q <= r_mask[w_mask_raddr];
        end
    end

    // First stage: decisions made at acceptance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv_s1) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_s1) begin
            r_s1_pix   <= w_is_pixel ? w_pv : '0;
            r_s1_cand  <= w_cand;
            r_s1_area  <= w_area;
            r_s1_shown <= r_cursor_valid && (n_hide == '0);
            r_s1_bit   <= ~w_dx_l[2:0];
        end
    end

    // Second stage: pick the cursor pixel where the mask bit is set.
    assign w_hit = r_s1_cand && r_mask_q[r_s1_bit];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_out) begin
            r_out_pixel <= w_hit ? r_img_q : r_s1_pix;
            r_out_hit   <= w_hit;
            r_out_area  <= r_s1_area;
            r_out_shown <= r_s1_shown;
        end
    end

    // Result port.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'(r_out_pixel);
    always_comb begin
        o_m_tuser                        = '0;
        o_m_tuser[cov_pkg::OU_HIT_BIT]   = r_out_hit;
        o_m_tuser[cov_pkg::OU_AREA_BIT]  = r_out_area;
        o_m_tuser[cov_pkg::OU_SHOWN_BIT] = r_out_shown;
    end

endmodule

`default_nettype wire

// ===== design/cov_checker.sv =====
// Port-level checks for the cursor overlay result stream, and the bind
// that attaches them to cursor_overlay. Depends on cov_pkg.
`default_nettype none

module cov_checker #(
    parameter int PIXEL_BITS = 32
) (
    input wire i_clk,
    input wire i_rst_n,
    input wire i_m_tready,
    input wire o_m_tvalid,
    input wire [((PIXEL_BITS+7)/8)*8-1:0] o_m_tdata,
    input wire [cov_pkg::OUT_USER_W-1:0] o_m_tuser
);

    // A stalled result keeps its contents until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("result changed while stalled");

    // The pipeline is empty in the cycle after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result presented straight after reset");

    // A cursor pixel can only be used while the cursor is shown.
    a_hit_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[cov_pkg::OU_HIT_BIT]) |->
            o_m_tuser[cov_pkg::OU_SHOWN_BIT])
        else $error("cursor hit while cursor hidden");

    // Overlap answers and overlay hits come from different requests.
    a_hit_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            !(o_m_tuser[cov_pkg::OU_HIT_BIT] && o_m_tuser[cov_pkg::OU_AREA_BIT]))
        else $error("hit and overlap flagged together");

    // An overlap answer carries no pixel.
    a_area_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[cov_pkg::OU_AREA_BIT]) |-> (o_m_tdata == '0))
        else $error("overlap result with non-zero pixel");

endmodule

bind cursor_overlay cov_checker #(
    .PIXEL_BITS(PIXEL_BITS)
) u_cov_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tready (i_m_tready),
    .o_m_tvalid (o_m_tvalid),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

// ===== tb/overlay_tb_pkg.sv =====
// Request and result types for the cursor overlay testbench, and the scoreboard
// that predicts each result and checks what the block returns.
// Depends on cov_pkg for action codes, register indexes and result bit positions.
package overlay_tb_pkg;

    import cov_pkg::*;

    localparam int CUR_MAX_W   = 64;
    localparam int CUR_MAX_H   = 64;
    localparam int STORE_DEPTH = CUR_MAX_W * CUR_MAX_H;

    // One request as it travels on the request stream.
    typedef struct {
        logic [ACTION_W-1:0] action;
        logic                kind_area;
        logic [11:0]         x;
        logic [11:0]         y;
        logic [12:0]         area_w;
        logic [12:0]         area_h;
        logic [31:0]         pixel;
        logic [MASK_W-1:0]   mask_bits;
    } overlay_req_t;

    // One result as it should appear on the result stream.
    typedef struct {
        logic [31:0] pixel;
        logic        hit;
        logic        area;
        logic        shown;
    } overlay_res_t;

    class overlay_scoreboard;
        // Register copies, at their reset values.
        logic [HOT_W-1:0]   hot_x;
        logic [HOT_W-1:0]   hot_y;
        logic [CSIZE_W-1:0] cur_w;
        logic [CSIZE_W-1:0] cur_h;
        logic [12:0]        scr_w;
        logic [12:0]        scr_h;
        logic               cur_valid;
        // Cursor state and the two stores, with a note of which entries are loaded.
        logic [HIDE_W-1:0]  hide_depth;
        logic [11:0]        pos_x;
        logic [11:0]        pos_y;
        logic [31:0]        image [STORE_DEPTH];
        bit                 mask [STORE_DEPTH];
        bit                 image_loaded [STORE_DEPTH];
        bit                 mask_loaded [STORE_DEPTH];
        overlay_res_t       expected_q [$];
        int                 errors;

        function new();
            hot_x      = '0;
            hot_y      = '0;
            cur_w      = '0;
            cur_h      = '0;
            scr_w      = 13'(SCREEN_W_RESET);
            scr_h      = 13'(SCREEN_H_RESET);
            cur_valid  = 1'b0;
            hide_depth = '0;
            pos_x      = '0;
            pos_y      = '0;
            errors     = 0;
            foreach (mask_loaded[i]) begin
                mask_loaded[i]  = 1'b0;
                image_loaded[i] = 1'b0;
            end
        endfunction

        // Cursor size as used, with oversized registers clipped to the store.
        function int span_w();
            return (cur_w > CUR_MAX_W) ? CUR_MAX_W : int'(cur_w);
        endfunction

        function int span_h();
            return (cur_h > CUR_MAX_H) ? CUR_MAX_H : int'(cur_h);
        endfunction

        // Top-left corner of the cursor rectangle on screen; may be negative.
        function int origin_x();
            return int'(pos_x) - int'(hot_x);
        endfunction

        function int origin_y();
            return int'(pos_y) - int'(hot_y);
        endfunction

        function bit cursor_shown();
            return cur_valid && (hide_depth == 0);
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [12:0] data);
            case (idx)
                CFG_HOT_X:         hot_x = data[HOT_W-1:0];
                CFG_HOT_Y:         hot_y = data[HOT_W-1:0];
                CFG_CURSOR_WIDTH:  cur_w = data[CSIZE_W-1:0];
                CFG_CURSOR_HEIGHT: cur_h = data[CSIZE_W-1:0];
                CFG_SCREEN_WIDTH:  scr_w = data;
                CFG_SCREEN_HEIGHT: scr_h = data;
                CFG_CURSOR_VALID: begin
                    cur_valid  = data[0];
                    hide_depth = '0;
                end
                default: ;
            endcase
        endfunction

        // A composited pixel may look up a store entry that was never loaded.
        // This returns the load request that fills the first such entry.
        function bit needs_fill(overlay_req_t r, output overlay_req_t fill);
            int dx;
            int dy;
            int idx;
            fill = r;
            if (r.action != ACT_PIXEL || r.kind_area || !cursor_shown() ||
                r.x >= scr_w || r.y >= scr_h)
                return 1'b0;
            dx = int'(r.x) - origin_x();
            dy = int'(r.y) - origin_y();
            if (dx < 0 || dx >= span_w() || dy < 0 || dy >= span_h())
                return 1'b0;
            idx = dy * CUR_MAX_W + dx;
            if (!mask_loaded[idx]) begin
                fill.action = ACT_LOAD_MASK;
                fill.x      = 12'(dx / 8);
                fill.y      = 12'(dy);
                return 1'b1;
            end
            if (mask[idx] && !image_loaded[idx]) begin
                fill.action = ACT_LOAD_PIXEL;
                fill.x      = 12'(dx);
                fill.y      = 12'(dy);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Apply an accepted request to the state and queue its result.
        function void note_request(overlay_req_t r);
            overlay_res_t res;
            int ox;
            int oy;
            int w;
            int h;
            int dx;
            int dy;
            int col;
            int idx;
            ox  = origin_x();
            oy  = origin_y();
            w   = span_w();
            h   = span_h();
            res = '{pixel: '0, hit: 1'b0, area: 1'b0, shown: 1'b0};
            case (r.action)
                ACT_LOAD_PIXEL: begin
                    if (r.x < CUR_MAX_W && r.y < CUR_MAX_H) begin
                        idx = int'(r.y) * CUR_MAX_W + int'(r.x);
                        image[idx]        = r.pixel;
                        image_loaded[idx] = 1'b1;
                    end
                end
                ACT_LOAD_MASK: begin
                    // Leftmost mask bit is the most significant one.
                    if (r.y < CUR_MAX_H) begin
                        for (int i = 0; i < MASK_W; i++) begin
                            col = int'(r.x) * MASK_W + i;
                            if (col < w) begin
                                idx = int'(r.y) * CUR_MAX_W + col;
                                mask[idx]        = r.mask_bits[MASK_W-1-i];
                                mask_loaded[idx] = 1'b1;
                            end
                        end
                    end
                end
                ACT_MOVE: begin
                    pos_x = r.x;
                    pos_y = r.y;
                end
                ACT_HIDE: begin
                    if (cur_valid && hide_depth != '1)
                        hide_depth = hide_depth + 1'b1;
                end
                ACT_SHOW: begin
                    if (cur_valid && hide_depth != '0)
                        hide_depth = hide_depth - 1'b1;
                end
                ACT_PIXEL: begin
                    if (r.kind_area) begin
                        res.area = cur_valid &&
                                   int'(r.x) < ox + w && int'(r.y) < oy + h &&
                                   int'(r.x) + int'(r.area_w) >= ox &&
                                   int'(r.y) + int'(r.area_h) >= oy;
                    end else begin
                        dx = int'(r.x) - ox;
                        dy = int'(r.y) - oy;
                        res.pixel = r.pixel;
                        if (cursor_shown() && r.x < scr_w && r.y < scr_h &&
                            dx >= 0 && dx < w && dy >= 0 && dy < h) begin
                            idx = dy * CUR_MAX_W + dx;
                            if (mask[idx]) begin
                                res.pixel = image[idx];
                                res.hit   = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            res.shown = cursor_shown();
            expected_q.push_back(res);
        endfunction

        // Compare one returned result with the oldest prediction.
        function void check_result(logic [31:0] pixel, logic [OUT_USER_W-1:0] flags);
            overlay_res_t want;
            if (expected_q.size() == 0) begin
                $error("result with nothing outstanding: out_pixel %h flags %b", pixel, flags);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (pixel !== want.pixel) begin
                $error("out_pixel: expected %h, got %h", want.pixel, pixel);
                errors++;
            end
            if (flags[OU_HIT_BIT] !== want.hit) begin
                $error("cursor_hit: expected %b, got %b", want.hit, flags[OU_HIT_BIT]);
                errors++;
            end
            if (flags[OU_AREA_BIT] !== want.area) begin
                $error("in_area: expected %b, got %b", want.area, flags[OU_AREA_BIT]);
                errors++;
            end
            if (flags[OU_SHOWN_BIT] !== want.shown) begin
                $error("cursor_shown: expected %b, got %b", want.shown, flags[OU_SHOWN_BIT]);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== tb/tb.sv =====
// Top-level testbench for cursor_overlay: directed and random requests with random
// stalls on both streams, register changes between phases, checked by the scoreboard.
// Depends on cov_pkg, overlay_tb_pkg and the cursor_overlay RTL.
`timescale 1ns / 1ps

module tb;

    import cov_pkg::*;
    import overlay_tb_pkg::*;

    localparam int COORD_BITS   = 12;
    localparam int PIXEL_BITS   = 32;
    localparam int TDATA_W      = ((4*COORD_BITS+2+PIXEL_BITS+MASK_W+7)/8)*8;
    localparam int IDLE_LIMIT   = 1000;
    localparam int LONG_HOLD    = 64;
    localparam int RANDOM_ITEMS = 1600;
    localparam int SETTLE       = 4;

    // Action codes the block does not define; they must change nothing.
    localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;
    localparam logic KIND_OVERLAY = 1'b0;
    localparam logic KIND_AREA    = 1'b1;

    typedef struct {
        int unsigned hot_x;
        int unsigned hot_y;
        int unsigned cur_w;
        int unsigned cur_h;
        int unsigned scr_w;
        int unsigned scr_h;
        int unsigned valid;
    } cursor_cfg_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata = '0;
    logic [ACTION_W:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [31:0]            m_tdata;
    logic [OUT_USER_W-1:0]  m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [COORD_BITS:0]    cfg_data = '0;

    overlay_scoreboard sb;
    bit sender_burst = 1'b0;
    int hold_asks = 0;
    int holds_done = 0;
    int idle_cycles = 0;

    cursor_overlay dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // End the run if nothing moves on any channel for too long.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stalls, eager stretches, and the occasional long hold.
    initial begin : result_sink
        int gap;
        bit eager;
        eager = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (holds_done != hold_asks) begin
                gap = LONG_HOLD;
                holds_done++;
            end else if (eager) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 4);
            end
            if ($urandom_range(0, 39) == 0)
                eager = !eager;
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            sb.check_result(m_tdata, m_tuser);
        end
    end

    function automatic overlay_req_t make_req(logic [ACTION_W-1:0] action, logic kind,
                                              int x, int y, int aw, int ah,
                                              logic [31:0] pixel, logic [MASK_W-1:0] bits);
        overlay_req_t r;
        r.action    = action;
        r.kind_area = kind;
        r.x         = 12'(x);
        r.y         = 12'(y);
        r.area_w    = 13'(aw);
        r.area_h    = 13'(ah);
        r.pixel     = pixel;
        r.mask_bits = bits;
        return r;
    endfunction

    // A coordinate a little around the span starting at base, kept on the grid.
    function automatic logic [11:0] near_coord(int base, int span);
        int v;
        v = base + int'($urandom_range(0, span + 3)) - 2;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return 12'(v);
    endfunction

    // Random request, half of them aimed at the cursor; unused fields stay random.
    function automatic overlay_req_t draw_item();
        overlay_req_t r;
        int pick;
        int lim;
        r = make_req(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                     $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 8191), $urandom_range(0, 8191),
                     $urandom(), 8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            r.action    = ACT_PIXEL;
            r.kind_area = KIND_OVERLAY;
            r.x         = near_coord(sb.origin_x(), sb.span_w());
            r.y         = near_coord(sb.origin_y(), sb.span_h());
        end else if (pick < 50) begin
            r.action    = ACT_PIXEL;
            r.kind_area = KIND_AREA;
            r.x         = near_coord(sb.origin_x() - 12, sb.span_w() + 16);
            r.y         = near_coord(sb.origin_y() - 12, sb.span_h() + 16);
            if ($urandom_range(0, 3) != 0) begin
                r.area_w = 13'($urandom_range(0, 20));
                r.area_h = 13'($urandom_range(0, 20));
            end
        end else if (pick < 60) begin
            r.action = ACT_LOAD_PIXEL;
            if ($urandom_range(0, 7) != 0) begin
                r.x = 12'($urandom_range(0, CUR_MAX_W - 1));
                r.y = 12'($urandom_range(0, CUR_MAX_H - 1));
            end
        end else if (pick < 68) begin
            r.action = ACT_LOAD_MASK;
            if ($urandom_range(0, 7) != 0) begin
                r.x = 12'($urandom_range(0, CUR_MAX_W / MASK_W - 1));
                r.y = 12'($urandom_range(0, CUR_MAX_H - 1));
            end
        end else if (pick < 74) begin
            // Keep the cursor on screen most of the time so that it can hit.
            r.action = ACT_MOVE;
            if ($urandom_range(0, 3) != 0) begin
                lim = (sb.scr_w == 0 || sb.scr_w > 4096) ? 4096 : int'(sb.scr_w);
                r.x = 12'($urandom_range(0, lim - 1));
                lim = (sb.scr_h == 0 || sb.scr_h > 4096) ? 4096 : int'(sb.scr_h);
                r.y = 12'($urandom_range(0, lim - 1));
            end
        end else if (pick < 80) begin
            r.action = ACT_HIDE;
        end else if (pick < 86) begin
            r.action = ACT_SHOW;
        end else if (pick < 90) begin
            r.action = ($urandom_range(0, 1) != 0) ? ACT_SPARE_A : ACT_SPARE_B;
        end
        return r;
    endfunction

    // Register settings per phase; the first few phases take the extremes.
    function automatic cursor_cfg_t draw_cfg(int phase);
        cursor_cfg_t c;
        c.hot_x = $urandom_range(0, 63);
        c.hot_y = $urandom_range(0, 63);
        c.cur_w = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 16) : $urandom_range(0, 127);
        c.cur_h = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 16) : $urandom_range(0, 127);
        c.scr_w = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 4096) : $urandom_range(0, 8191);
        c.scr_h = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 4096) : $urandom_range(0, 8191);
        c.valid = ($urandom_range(0, 7) != 0);
        case (phase)
            0: c = '{hot_x: 63, hot_y: 63, cur_w: 64, cur_h: 64,
                     scr_w: 4096, scr_h: 4096, valid: 1};
            1: c = '{hot_x: 0, hot_y: 0, cur_w: 127, cur_h: 127,
                     scr_w: 1, scr_h: 1, valid: 1};
            2: c = '{hot_x: c.hot_x, hot_y: c.hot_y, cur_w: 0, cur_h: 0,
                     scr_w: 0, scr_h: 0, valid: 1};
            3: c.valid = 0;
            4: begin
                c.scr_w = 8191;
                c.scr_h = 8191;
            end
            5: begin
                c.scr_w = 0;
                c.valid = 1;
            end
            default: ;
        endcase
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 13'(value);
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        sb.note_config(idx, 13'(value));
    endtask

    task automatic configure(input cursor_cfg_t c, input logic [6:0] which);
        if (which[0]) write_reg(CFG_HOT_X, c.hot_x);
        if (which[1]) write_reg(CFG_HOT_Y, c.hot_y);
        if (which[2]) write_reg(CFG_CURSOR_WIDTH, c.cur_w);
        if (which[3]) write_reg(CFG_CURSOR_HEIGHT, c.cur_h);
        if (which[4]) write_reg(CFG_SCREEN_WIDTH, c.scr_w);
        if (which[5]) write_reg(CFG_SCREEN_HEIGHT, c.scr_h);
        if (which[6]) write_reg(CFG_CURSOR_VALID, c.valid);
        cfg_valid <= 1'b0;
    endtask

    // Present one request and wait for it to be taken.
    task automatic offer(input overlay_req_t r);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({r.mask_bits, r.pixel, r.area_h, r.area_w, r.y, r.x});
        s_tuser  <= {r.kind_area, r.action};
        do @(posedge clk); while (!(s_tvalid && s_tready));
        sb.note_request(r);
    endtask

    // Load any store entry the request would look up before sending it.
    task automatic send(input overlay_req_t r);
        overlay_req_t fill;
        while (sb.needs_fill(r, fill))
            offer(fill);
        offer(r);
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial begin : stimulus
        cursor_cfg_t c;
        overlay_req_t r;
        int sent;
        int phase;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no cursor, so pixels pass and hide and show do nothing.
        send(make_req(ACT_PIXEL, KIND_OVERLAY, 4095, 4095, 0, 0, 32'hFFFF_FFFF, 8'hFF));
        send(make_req(ACT_PIXEL, KIND_OVERLAY, 0, 0, 8191, 8191, 32'h0, 8'h00));
        send(make_req(ACT_PIXEL, KIND_AREA, 0, 0, 8191, 8191, 32'h0, 8'h00));
        send(make_req(ACT_HIDE, KIND_OVERLAY, 0, 0, 0, 0, 32'h0, 8'h00));
        send(make_req(ACT_SHOW, KIND_OVERLAY, 0, 0, 0, 0, 32'h0, 8'h00));
        send(make_req(ACT_SPARE_A, KIND_AREA, 4095, 4095, 8191, 8191, 32'hFFFF_FFFF, 8'hFF));
        send(make_req(ACT_SPARE_B, KIND_AREA, 4095, 4095, 8191, 8191, 32'hFFFF_FFFF, 8'hFF));
        drain();

        // A 4 by 2 cursor with the hotspot at (2, 1).
        configure('{hot_x: 2, hot_y: 1, cur_w: 4, cur_h: 2,
                    scr_w: 1024, scr_h: 768, valid: 1}, 7'h7F);
        // Mask bits past the width, rows past the store and far columns are dropped.
        send(make_req(ACT_LOAD_MASK, KIND_OVERLAY, 0, 0, 0, 0, 32'h0, 8'hA5));
        send(make_req(ACT_LOAD_MASK, KIND_OVERLAY, 0, 1, 0, 0, 32'h0, 8'hFF));
        send(make_req(ACT_LOAD_MASK, KIND_OVERLAY, 0, 64, 0, 0, 32'h0, 8'h00));
        send(make_req(ACT_LOAD_MASK, KIND_OVERLAY, 4095, 0, 0, 0, 32'h0, 8'h00));
        send(make_req(ACT_LOAD_PIXEL, KIND_OVERLAY, 0, 0, 0, 0, 32'h1111_1111, 8'h00));
        send(make_req(ACT_LOAD_PIXEL, KIND_OVERLAY, 2, 0, 0, 0, 32'h2222_2222, 8'h00));
        send(make_req(ACT_LOAD_PIXEL, KIND_OVERLAY, 64, 0, 0, 0, 32'hDEAD_BEEF, 8'h00));
        send(make_req(ACT_LOAD_PIXEL, KIND_OVERLAY, 0, 64, 0, 0, 32'hDEAD_BEEF, 8'h00));
        send(make_req(ACT_MOVE, KIND_OVERLAY, 100, 50, 0, 0, 32'h0, 8'h00));
        // Cursor now spans columns 98 to 101 and rows 49 to 50.
        send(make_req(ACT_PIXEL, KIND_OVERLAY, 98, 49, 0, 0, 32'h0BAD_F00D, 8'h00));
        send(make_req(ACT_PIXEL, KIND_OVERLAY, 99, 49, 0, 0, 32'h0BAD_F00D, 8'h00));
        send(make_req(ACT_PIXEL, KIND_OVERLAY, 97, 49, 0, 0, 32'h0BAD_F00D, 8'h00));
        // Area queries that just touch and just miss the cursor rectangle.
        send(make_req(ACT_PIXEL, KIND_AREA, 90, 40, 8, 9, 32'h0, 8'h00));
        send(make_req(ACT_PIXEL, KIND_AREA, 102, 49, 0, 0, 32'h0, 8'h00));
        // Hide blocks the hit; the second show finds the count already at zero.
        send(make_req(ACT_HIDE, KIND_OVERLAY, 0, 0, 0, 0, 32'h0, 8'h00));
        send(make_req(ACT_PIXEL, KIND_OVERLAY, 100, 49, 0, 0, 32'h1234_5678, 8'h00));
        send(make_req(ACT_SHOW, KIND_OVERLAY, 0, 0, 0, 0, 32'h0, 8'h00));
        send(make_req(ACT_SHOW, KIND_OVERLAY, 0, 0, 0, 0, 32'h0, 8'h00));
        send(make_req(ACT_PIXEL, KIND_OVERLAY, 100, 49, 0, 0, 32'h1234_5678, 8'h00));

        // Random phases, each with new register settings written while idle.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            drain();
            c = draw_cfg(phase);
            if (phase == 6)
                c.valid = 1;
            configure(c, (phase == 0 || phase == 6) ? 7'h7F : 7'($urandom_range(1, 127)));
            sender_burst = (phase % 3 == 0);
            // Hold the result side off while requests keep coming, to fill the pipeline.
            if (phase == 3 || phase == 9)
                hold_asks++;
            // Push the hide count into saturation, then step it back a little.
            if (phase == 6) begin
                repeat (262) begin
                    r = draw_item();
                    r.action = ACT_HIDE;
                    send(r);
                end
                sent += 262;
            end
            repeat ($urandom_range(60, 140)) begin
                send(draw_item());
                sent++;
            end
            phase++;
        end
        drain();

        if (sb.expected_q.size() != 0) begin
            $error("%0d results never arrived", sb.expected_q.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
